// ----- rtl/core/avasc_pkg.sv -----
// Package for the additive-substitution AES variant: shared types, constants and
// byte-level round functions (add/sub of key bytes, ShiftRows, MixColumns, S-box).
// Depends on nothing; every other file of the block imports it.
package avasc_pkg;

    // Number of round-key slots.
    localparam int NUM_RK    = 15;
    localparam int RIDX_W    = $clog2(NUM_RK);
    localparam int WIDX_W    = $clog2(4 * NUM_RK);
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_0      = 3'd0,
        REG_KEY_1      = 3'd1,
        REG_KEY_2      = 3'd2,
        REG_KEY_3      = 3'd3,
        REG_KEY_LENGTH = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0,
        KEY_192 = 2'd1,
        KEY_256 = 2'd2
    } key_len_t;

    localparam logic CMD_DECRYPT = 1'b1;

    typedef enum logic {
        KS_IDLE,
        KS_EXPAND
    } ks_state_t;

    typedef struct packed {
        logic        cmd;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } block_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } result_t;

    typedef struct packed {
        logic         decrypt;
        logic [127:0] state;
    } pipe_t;

    typedef struct packed {
        logic active;
        logic last;
    } round_ctrl_t;

    typedef logic [127:0] rkey_t;
    typedef rkey_t key_array_t [NUM_RK];

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte p of a block sits at row p%4, column p/4. Row r, column c of the state
    // gets key byte 4r+c of round key zero added (or subtracted).
    function automatic logic [127:0] add_sub(input logic [127:0] s, input logic [127:0] k0,
                                             input logic sub);
        logic [127:0] o;
        logic [7:0]   kb;
        o = '0;
        for (int p = 0; p < 16; p++) begin
            kb = k0[127 - 8 * (4 * (p % 4) + p / 4) -: 8];
            o[127 - 8 * p -: 8] = sub ? s[127 - 8 * p -: 8] - kb : s[127 - 8 * p -: 8] + kb;
        end
        return o;
    endfunction

    function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        int           src;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                o[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * (r + 4 * src) -: 8];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] column_mix(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [7:0]   a  [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        logic [7:0]   m1 [4];
        logic [7:0]   m2 [4];
        logic [7:0]   m3 [4];
        logic [7:0]   m9 [4];
        logic [7:0]   mb [4];
        logic [7:0]   md [4];
        logic [7:0]   me [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[127 - 8 * (k + 4 * c) -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
                m1[k] = a[k];
                m2[k] = x2[k];
                m3[k] = x2[k] ^ a[k];
                m9[k] = x8[k] ^ a[k];
                mb[k] = x8[k] ^ x2[k] ^ a[k];
                md[k] = x8[k] ^ x4[k] ^ a[k];
                me[k] = x8[k] ^ x4[k] ^ x2[k];
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    o[127 - 8 * (r + 4 * c) -: 8] = me[r] ^ mb[(r + 1) % 4]
                                                  ^ md[(r + 2) % 4] ^ m9[(r + 3) % 4];
                end
                else begin
                    o[127 - 8 * (r + 4 * c) -: 8] = m2[r] ^ m3[(r + 1) % 4]
                                                  ^ m1[(r + 2) % 4] ^ m1[(r + 3) % 4];
                end
            end
        end
        return o;
    endfunction

endpackage

// ----- rtl/core/avasc_key_sched.sv -----
// Key registers and key-schedule sequencer: one 32-bit schedule word per cycle,
// stored in encrypt-order and decrypt-order round-key banks. Uses avasc_pkg.
module avasc_key_sched (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [avasc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                      cfg_data,
    output logic                             busy,
    output logic [avasc_pkg::RIDX_W-1:0]     num_rounds,
    output avasc_pkg::key_array_t            enc_keys,
    output avasc_pkg::key_array_t            dec_keys
);
    import avasc_pkg::*;

    logic [63:0]       key_reg [4];
    logic [1:0]        klen_reg;
    ks_state_t         state_reg, state_next;
    logic [WIDX_W-1:0] idx_reg, idx_next;
    logic [2:0]        ctr_reg, ctr_next;
    logic [7:0]        rc_reg, rc_next;
    logic [31:0]       win_reg [8];
    logic [31:0]       enc_reg [NUM_RK][4];
    logic [31:0]       dec_reg [NUM_RK][4];

    logic              restart;
    logic              expanding;
    logic [3:0]        nk;
    logic [WIDX_W-1:0] last_idx;
    logic [31:0]       key_word;
    logic [31:0]       back_word;
    logic [31:0]       tmp;
    logic [31:0]       word;
    logic              from_key;
    logic              on_boundary;
    logic [RIDX_W-1:0] enc_slot;
    logic [RIDX_W-1:0] dec_slot;

    assign restart = cfg_write && (cfg_index <= REG_KEY_LENGTH);

    always_comb
    begin
        case (key_len_t'(klen_reg))
            KEY_192:
            begin
                num_rounds = RIDX_W'(12);
                nk         = 4'd6;
                back_word  = win_reg[5];
            end
            KEY_256:
            begin
                num_rounds = RIDX_W'(14);
                nk         = 4'd8;
                back_word  = win_reg[7];
            end
            default:
            begin
                num_rounds = RIDX_W'(10);
                nk         = 4'd4;
                back_word  = win_reg[3];
            end
        endcase
    end

    assign last_idx = {num_rounds, 2'b11};
    assign key_word = idx_reg[0] ? key_reg[idx_reg[2:1]][31:0] : key_reg[idx_reg[2:1]][63:32];
    assign from_key = idx_reg < WIDX_W'(nk);
    assign on_boundary = (ctr_reg == 3'd0);

    always_comb
    begin
        if (on_boundary) begin
            tmp = sbox_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rc_reg, 24'h0};
        end
        else if ((nk == 4'd8) && (ctr_reg == 3'd4)) begin
            tmp = sbox_word(win_reg[0]);
        end
        else begin
            tmp = win_reg[0];
        end
    end

    assign word     = from_key ? key_word : (back_word ^ tmp);
    assign enc_slot = idx_reg[WIDX_W-1:2];
    assign dec_slot = num_rounds - idx_reg[WIDX_W-1:2];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            KS_IDLE:
            begin
                if (restart) begin
                    state_next = KS_EXPAND;
                end
            end
            KS_EXPAND:
            begin
                if (!restart && (idx_reg == last_idx)) begin
                    state_next = KS_IDLE;
                end
            end
            default: state_next = KS_EXPAND;
        endcase
    end

    // Output logic.
    always_comb
    begin
        case (state_reg)
            KS_EXPAND: expanding = 1'b1;
            default:   expanding = 1'b0;
        endcase
    end

    assign busy = expanding;

    always_comb
    begin
        idx_next = idx_reg;
        ctr_next = ctr_reg;
        rc_next  = rc_reg;
        if (restart) begin
            idx_next = '0;
            ctr_next = '0;
            rc_next  = 8'h01;
        end
        else if (expanding) begin
            idx_next = idx_reg + WIDX_W'(1);
            ctr_next = (ctr_reg == 3'(nk - 4'd1)) ? 3'd0 : ctr_reg + 3'd1;
            if (!from_key && on_boundary) begin
                rc_next = xtime(rc_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= KS_EXPAND;
            idx_reg   <= '0;
            ctr_reg   <= '0;
            rc_reg    <= 8'h01;
            klen_reg  <= '0;
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
        end
        else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ctr_reg   <= ctr_next;
            rc_reg    <= rc_next;
            if (cfg_write) begin
                case (cfg_reg_t'(cfg_index))
                    REG_KEY_0:      key_reg[0] <= cfg_data;
                    REG_KEY_1:      key_reg[1] <= cfg_data;
                    REG_KEY_2:      key_reg[2] <= cfg_data;
                    REG_KEY_3:      key_reg[3] <= cfg_data;
                    REG_KEY_LENGTH: klen_reg   <= cfg_data[1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (expanding) begin
            win_reg[0] <= word;
            for (int i = 1; i < 8; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
            enc_reg[enc_slot][idx_reg[1:0]] <= word;
            dec_reg[dec_slot][idx_reg[1:0]] <= word;
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_RK; r++) begin
            enc_keys[r] = {enc_reg[r][0], enc_reg[r][1], enc_reg[r][2], enc_reg[r][3]};
            dec_keys[r] = {dec_reg[r][0], dec_reg[r][1], dec_reg[r][2], dec_reg[r][3]};
        end
    end

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == KS_EXPAND) |-> (idx_reg <= last_idx))
        else $error("key schedule index ran past the last word");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == KS_EXPAND) && (idx_reg == last_idx) && !restart) |=>
        (state_reg == KS_IDLE))
        else $error("key schedule did not stop after the last word");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> ((state_reg == KS_EXPAND) && (idx_reg == '0)))
        else $error("key schedule did not restart from the first word");
`endif

endmodule

// ----- rtl/core/avasc_round.sv -----
// One pipelined cipher round, encrypt or decrypt per item, with a bypass for
// rounds beyond the key length's round count. Uses avasc_pkg round functions.
module avasc_round (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  avasc_pkg::pipe_t       in_data,
    input  avasc_pkg::round_ctrl_t ctrl,
    input  avasc_pkg::rkey_t       enc_key,
    input  avasc_pkg::rkey_t       dec_key,
    input  avasc_pkg::rkey_t       sub_key,
    output logic                   out_valid,
    output avasc_pkg::pipe_t       out_data
);
    import avasc_pkg::*;

    logic         valid_reg;
    pipe_t        data_reg;
    logic [127:0] enc_a, enc_b, enc_c;
    logic [127:0] dec_a, dec_b, dec_c;
    logic [127:0] state_next;

    always_comb
    begin
        enc_a = row_rotate(add_sub(in_data.state, sub_key, 1'b0), 1'b0);
        enc_b = ctrl.last ? enc_a : column_mix(enc_a, 1'b0);
        enc_c = enc_b ^ enc_key;

        dec_a = add_sub(row_rotate(in_data.state, 1'b1), sub_key, 1'b1);
        dec_b = dec_a ^ dec_key;
        dec_c = ctrl.last ? dec_b : column_mix(dec_b, 1'b1);

        if (!ctrl.active) begin
            state_next = in_data.state;
        end
        else if (in_data.decrypt == CMD_DECRYPT) begin
            state_next = dec_c;
        end
        else begin
            state_next = enc_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg.decrypt <= in_data.decrypt;
        data_reg.state   <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/core/aes_variant_additive_sub_cipher_unit.sv -----
// One block per cycle while busy is low; done timing is the same for all key lengths.
// A 15-stage round pipeline, one register stage per round.
// After reset and after each key register write, busy is high while the key schedule
// produces one word per cycle, until the last round key is written.
// Reset is asynchronous and active low; it clears the keys and starts a schedule.
// Results are strobed for one cycle; the receiver cannot stall.
module aes_variant_additive_sub_cipher_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  avasc_pkg::block_t                block,
    output logic                             done,
    output avasc_pkg::result_t               result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [avasc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                      cfg_data
);
    import avasc_pkg::*;

    localparam int LAST_STAGE = NUM_RK - 1;

    logic              accept;
    logic [RIDX_W-1:0] num_rounds;
    key_array_t        enc_keys;
    key_array_t        dec_keys;
    logic              stage_valid [NUM_RK];
    pipe_t             stage_data  [NUM_RK];
    logic              s0_valid_reg;
    pipe_t             s0_reg;

    // Configuration writes are always taken; a write to a key register restarts
    // the key schedule, which holds the block busy until it completes.
    assign cfg_ready = 1'b1;

    avasc_key_sched u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .busy       (busy),
        .num_rounds (num_rounds),
        .enc_keys   (enc_keys),
        .dec_keys   (dec_keys)
    );

    // A transaction is accepted whenever the key schedule is settled.
    assign accept = start && !busy;

    // Stage zero performs the initial key addition: round key zero for
    // encryption, the last round key for decryption (slot zero of the
    // decrypt-order bank).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
        end
        else begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg.decrypt <= block.cmd;
        s0_reg.state   <= {block.block_high, block.block_low}
                        ^ ((block.cmd == CMD_DECRYPT) ? dec_keys[0] : enc_keys[0]);
    end

    assign stage_valid[0] = s0_valid_reg;
    assign stage_data[0]  = s0_reg;

    // Rounds 1 to Nr run in stages 1 to Nr; round Nr omits MixColumns. Stages
    // past Nr pass the state through so that latency does not depend on key length.
    for (genvar g = 1; g < NUM_RK; g++)
    begin : g_round
        round_ctrl_t ctrl;

        assign ctrl.active = (RIDX_W'(g) <= num_rounds);
        assign ctrl.last   = (RIDX_W'(g) == num_rounds);

        avasc_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g-1]),
            .in_data   (stage_data[g-1]),
            .ctrl      (ctrl),
            .enc_key   (enc_keys[g]),
            .dec_key   (dec_keys[g]),
            .sub_key   (enc_keys[0]),
            .out_valid (stage_valid[g]),
            .out_data  (stage_data[g])
        );
    end

    assign done            = stage_valid[LAST_STAGE];
    assign result.out_high = stage_data[LAST_STAGE].state[127:64];
    assign result.out_low  = stage_data[LAST_STAGE].state[63:0];

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##15 done)
        else $error("accepted transaction produced no result strobe");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 15))
        else $error("result strobe does not match an accepted transaction");

    a_no_entry_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !s0_valid_reg)
        else $error("transaction entered the pipeline during key expansion");
`endif

endmodule

// ----- sim/cipher_checker.sv -----
// Checker for the additive-substitution AES variant: watches the block, key
// and result channels, predicts every result and compares it field by field.
// Depends on avasc_pkg for the payload types, register indexes and S-box table.
module cipher_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  avasc_pkg::block_t               block,
    input  logic                            done,
    input  avasc_pkg::result_t              result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [avasc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    output int                              errors,
    output int                              pending
);
    import avasc_pkg::*;

    logic [63:0] key_word [4];
    logic [1:0]  key_code;
    logic [7:0]  round_key [NUM_RK][16];
    int          rounds;
    result_t     expected_results [$];

    assign pending = expected_results.size();

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                p ^= a;
            a = dbl(a);
        end
        return p;
    endfunction

    // Standard key expansion; rounds follow the key length code, code three
    // falls back to the 128-bit schedule.
    function automatic void expand_schedule();
        logic [7:0] kb [32];
        logic [7:0] w [4 * NUM_RK * 4];
        logic [7:0] t [4];
        logic [7:0] x;
        logic [7:0] rc;
        int         nk;
        int         nr;
        for (int i = 0; i < 32; i++)
            kb[i] = key_word[i / 8][63 - 8 * (i % 8) -: 8];
        if (key_code == KEY_192)
        begin
            nk = 6;
            nr = 12;
        end
        else if (key_code == KEY_256)
        begin
            nk = 8;
            nr = 14;
        end
        else
        begin
            nk = 4;
            nr = 10;
        end
        if (nr > NUM_RK - 1)
            nr = NUM_RK - 1;
        rounds = nr;
        rc = 8'h01;
        foreach (w[i])
            w[i] = 8'h00;
        for (int i = 0; i < 4 * nk; i++)
            w[i] = kb[i];
        for (int i = nk; i < 4 * (nr + 1); i++)
        begin
            for (int b = 0; b < 4; b++)
                t[b] = w[4 * (i - 1) + b];
            if (i % nk == 0)
            begin
                x = t[0];
                t[0] = t[1];
                t[1] = t[2];
                t[2] = t[3];
                t[3] = x;
                for (int b = 0; b < 4; b++)
                    t[b] = SBOX[t[b]];
                t[0] ^= rc;
                rc = dbl(rc);
            end
            else if (nk > 6 && i % nk == 4)
            begin
                for (int b = 0; b < 4; b++)
                    t[b] = SBOX[t[b]];
            end
            for (int b = 0; b < 4; b++)
                w[4 * i + b] = w[4 * (i - nk) + b] ^ t[b];
        end
        for (int r = 0; r < NUM_RK; r++)
            for (int b = 0; b < 16; b++)
                round_key[r][b] = (r <= nr) ? w[16 * r + b] : 8'h00;
    endfunction

    // The working state is packed row-major: byte 4*row+col at the top end.
    function automatic logic [127:0] add_round(input logic [127:0] s, input int n);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                s[127 - 8 * (4 * r + c) -: 8] ^= round_key[n][4 * c + r];
        return s;
    endfunction

    function automatic logic [127:0] add_key0(input logic [127:0] s, input logic sub);
        for (int i = 0; i < 16; i++)
            s[127 - 8 * i -: 8] = sub ? s[127 - 8 * i -: 8] - round_key[0][i]
                                      : s[127 - 8 * i -: 8] + round_key[0][i];
        return s;
    endfunction

    function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                o[127 - 8 * (4 * r + c) -: 8] =
                    s[127 - 8 * (4 * r + (inv ? (c + 4 - r) % 4 : (c + r) % 4)) -: 8];
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [7:0]   m [4];
        logic [7:0]   v;
        logic [127:0] o;
        if (inv)
        begin
            m[0] = 8'h0e;
            m[1] = 8'h0b;
            m[2] = 8'h0d;
            m[3] = 8'h09;
        end
        else
        begin
            m[0] = 8'h02;
            m[1] = 8'h03;
            m[2] = 8'h01;
            m[3] = 8'h01;
        end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v ^= gmul(m[(k + 4 - r) % 4], s[127 - 8 * (4 * k + c) -: 8]);
                o[127 - 8 * (4 * r + c) -: 8] = v;
            end
        return o;
    endfunction

    function automatic result_t crypt_block(input block_t b);
        logic [127:0] flat;
        logic [127:0] s;
        result_t      res;
        flat = {b.block_high, b.block_low};
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                s[127 - 8 * (4 * r + c) -: 8] = flat[127 - 8 * (r + 4 * c) -: 8];
        if (b.cmd != CMD_DECRYPT)
        begin
            s = add_round(s, 0);
            for (int n = 1; n < rounds; n++)
                s = add_round(mix_cols(rotate_rows(add_key0(s, 1'b0), 1'b0), 1'b0), n);
            s = add_round(rotate_rows(add_key0(s, 1'b0), 1'b0), rounds);
        end
        else
        begin
            s = add_round(s, rounds);
            for (int n = rounds - 1; n >= 1; n--)
                s = mix_cols(add_round(add_key0(rotate_rows(s, 1'b1), 1'b1), n), 1'b1);
            s = add_round(add_key0(rotate_rows(s, 1'b1), 1'b1), 0);
        end
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                flat[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * (4 * r + c) -: 8];
        res.out_high = flat[127:64];
        res.out_low  = flat[63:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            foreach (key_word[i])
                key_word[i] = '0;
            key_code = '0;
            expand_schedule();
            errors = 0;
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("checker: result %h_%h with nothing expected",
                                 result.out_high, result.out_low);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.out_high !== want.out_high || result.out_low !== want.out_low)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("checker: expected %h_%h, got %h_%h",
                                     want.out_high, want.out_low,
                                     result.out_high, result.out_low);
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(crypt_block(block));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index <= REG_KEY_3)
                begin
                    key_word[cfg_index[1:0]] = cfg_data;
                    expand_schedule();
                end
                else if (cfg_index == REG_KEY_LENGTH)
                begin
                    key_code = cfg_data[1:0];
                    expand_schedule();
                end
            end
        end
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the testbench for the additive-substitution AES variant: clock, reset,
// block and key stimulus, and the verdict. Depends on avasc_pkg, the cipher unit
// and cipher_checker, which does all prediction and comparison.
module testbench;
    import avasc_pkg::*;

    // Register indexes past the key length register are unused; writes there
    // must leave the keys alone.
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    // Enough for the 15-stage pipeline plus the longest key schedule.
    localparam int SETTLE_CYCLES = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    block_t               block;
    logic                 done;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    int                   errors;
    int                   pending;
    int                   cycles;
    bit                   no_gaps;

    aes_variant_additive_sub_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .block     (block),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cipher_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .block     (block),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // One key register transaction. The valid line drops at the accepting edge.
    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        if (!no_gaps && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Issue one block transaction. Start stays high between back-to-back blocks
    // and only drops when a random gap is inserted or the pipeline is drained.
    task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo);
        block_t b;
        if (!no_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        b.cmd        = cmd;
        b.block_high = hi;
        b.block_low  = lo;
        start <= 1'b1;
        block <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Keys may only change once every result is back and the pipeline is empty.
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_keys(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [1:0] code);
        write_key_reg(REG_KEY_0, k0);
        write_key_reg(REG_KEY_1, k1);
        write_key_reg(REG_KEY_2, k2);
        write_key_reg(REG_KEY_3, k3);
        // Upper data bits are random; only the low two bits select the length.
        write_key_reg(REG_KEY_LENGTH, {62'(rand64()), code});
        write_key_reg(CFG_IDX_W'($urandom_range(REG_KEY_LENGTH + 1, REG_TOP_INDEX)),
                      rand64());
    endtask

    initial
    begin
        logic [1:0] code;
        rst_n     = 1'b0;
        start     = 1'b0;
        block     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_gaps   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed blocks under the all-zero reset key: field extremes in both
        // directions.
        send_block(1'b0, 64'h0, 64'h0);
        send_block(CMD_DECRYPT, 64'h0, 64'h0);
        send_block(1'b0, '1, '1);
        send_block(CMD_DECRYPT, '1, '1);
        send_block(1'b0, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef);
        send_block(CMD_DECRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        drain();

        // Each phase loads a key set, then runs random blocks. Length code
        // three must behave as the 128-bit schedule; extremes of the key bits
        // come in the early phases.
        for (int phase = 0; phase < 8; phase++)
        begin
            code = 2'(phase % 4);
            if (phase == 0)
                load_keys('1, '1, '1, '1, KEY_256);
            else if (phase == 1)
                load_keys('0, '0, '0, '0, KEY_192);
            else if (phase == 2)
                load_keys('1, '1, '1, '1, 2'd3);
            else
                load_keys(rand64(), rand64(), rand64(), rand64(), code);
            no_gaps = (phase == 7);
            if (phase < 3)
            begin
                send_block(1'b0, '1, 64'h0);
                send_block(CMD_DECRYPT, 64'h0, '1);
            end
            repeat (90)
                send_block(1'($urandom_range(0, 1)), rand64(), rand64());
            drain();
        end

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
